// ===== sv/weekly_alarm_next_event_unit_macros.svh =====
// Assertion macros for the alarm unit.
`ifndef WEEKLY_ALARM_NEXT_EVENT_UNIT_MACROS_SVH
`define WEEKLY_ALARM_NEXT_EVENT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define WANE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define WANE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WANE_ASSERT(label, prop, msg)
`define WANE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/wane_pkg.sv =====
`default_nettype none
package wane_pkg;

    localparam logic [2:0] STATUS_INSERTED = 3'd0;
    localparam logic [2:0] STATUS_UPDATED  = 3'd1;
    localparam logic [2:0] STATUS_REMOVED  = 3'd2;
    localparam logic [2:0] STATUS_FULL     = 3'd3;
    localparam logic [2:0] STATUS_QUERY    = 3'd4;

    localparam logic OP_SET   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [30:0] NONE_MATCHED_MS = 31'd2073600000;
    localparam logic [30:0] MS_PER_DAY      = 31'd86400000;
    localparam logic [26:0] MIN_SCHED_RESET = 27'd60000;
    localparam logic [9:0]  MS_PER_SEC      = 10'd1000;

    typedef struct packed {
        logic        operation;
        logic [16:0] alarm_second;
        logic [6:0]  alarm_days;
        logic [19:0] repeat_secs;
        logic [26:0] now_ms;
        logic [2:0]  now_weekday;
    } wane_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [30:0] to_go_ms;
        logic        found;
    } wane_out_t;

    typedef struct packed {
        logic [16:0] second;
        logic [6:0]  days;
        logic [19:0] interval;
    } wane_entry_t;

    typedef struct packed {
        logic load_item;
        logic scan_set;
        logic next_idx;
        logic div_start;
        logic div_day;
        logic adjust;
        logic pick;
        logic commit_set;
        logic load_out;
    } wane_cmd_t;

    typedef struct packed {
        logic op_query;
        logic last_idx;
        logic entry_ok;
        logic div_done;
        logic day_done;
        logic togo_lt_best;
        logic out_busy;
    } wane_sts_t;

    // remainder by 7 of a 6-bit value (0 to 63), by conditional subtracts
    function automatic logic [2:0] mod7(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        if (r >= 6'd56) r = r - 6'd56;
        if (r >= 6'd28) r = r - 6'd28;
        if (r >= 6'd14) r = r - 6'd14;
        if (r >= 6'd7)  r = r - 6'd7;
        return r[2:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/wane_div.sv =====
`default_nettype none
module wane_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [30:0] divisor,
    output logic             done,
    output logic [30:0]      remainder
);
    logic [31:0] dvd_reg;
    logic [30:0] dsr_reg;
    logic [30:0] rem_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] partial;
    logic        ge;
    logic [31:0] diff;

    assign partial = {rem_reg, dvd_reg[31]};
    assign ge      = partial >= {1'b0, dsr_reg};
    assign diff    = partial - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[30:0], ge};
            rem_reg <= ge ? diff[30:0] : partial[30:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// ===== sv/wane_datapath.sv =====
`default_nettype none
module wane_datapath #(
    parameter int ALARM_ENTRIES = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire wane_pkg::wane_in_t  in_data,
    input  wire logic                cfg_valid,
    input  wire logic [26:0]         cfg_data,
    input  wire wane_pkg::wane_cmd_t cmd,
    output wane_pkg::wane_sts_t      sts,
    input  wire logic                m_ready,
    output logic                     m_valid,
    output wane_pkg::wane_out_t      m_data
);
    localparam int IDX_W = (ALARM_ENTRIES > 1) ? $clog2(ALARM_ENTRIES) : 1;

    wane_pkg::wane_entry_t table_mem [ALARM_ENTRIES];
    logic [ALARM_ENTRIES-1:0] valid_reg;

    wane_pkg::wane_in_t    item_reg;
    wane_pkg::wane_entry_t rd_entry_reg;
    logic                  ent_valid_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  match_hit_reg, free_hit_reg;
    logic [IDX_W-1:0]      match_idx_reg, free_idx_reg;
    logic [2:0]            set_status_reg;
    logic [26:0]           min_reg;
    logic [29:0]           ims_reg;
    logic                  neg_reg;
    logic [31:0]           togo_reg;
    logic [30:0]           best_reg;
    logic                  hit_reg;
    logic                  out_valid_reg;
    wane_pkg::wane_out_t   out_reg;
    logic [31:0]           day_rem_reg;
    logic [4:0]            day_cnt_reg;
    logic                  day_busy_reg;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    wane_pkg::wane_entry_t wr_entry;

    logic [26:0] sec_ms;
    logic [29:0] ims;
    logic        neg;
    logic [26:0] mag;
    logic [31:0] div_dividend;
    logic [30:0] div_divisor;
    logic        div_done;
    logic [30:0] div_rem;
    logic [31:0] togo0, togo_next;
    logic        day_left;
    logic [5:0]  day_sum;
    logic [2:0]  target;

    assign sec_ms = 27'(rd_entry_reg.second) * 27'(wane_pkg::MS_PER_SEC);
    assign ims    = 30'(rd_entry_reg.interval) * 30'(wane_pkg::MS_PER_SEC);
    assign neg    = item_reg.now_ms > sec_ms;
    assign mag    = neg ? item_reg.now_ms - sec_ms : sec_ms - item_reg.now_ms;

    assign div_dividend = {5'd0, mag};
    assign div_divisor  = {1'b0, ims};

    wane_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    // fold a negative difference into the positive residue, then hold off short times
    always_comb begin
        togo0 = (neg_reg && div_rem != '0) ? {2'd0, ims_reg} - {1'b0, div_rem}
                                           : {1'b0, div_rem};
        togo_next = (togo0 < {5'd0, min_reg}) ? togo0 + {2'd0, ims_reg} : togo0;
    end

    // count whole days of now plus the time to go, one day a cycle
    assign day_left = day_rem_reg >= {1'b0, wane_pkg::MS_PER_DAY};
    assign day_sum  = {3'd0, item_reg.now_weekday} + 6'd6 + {1'b0, day_cnt_reg};
    assign target   = wane_pkg::mod7(day_sum);

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = match_hit_reg ? match_idx_reg : free_idx_reg;
        wr_entry = '{second: item_reg.alarm_second, days: item_reg.alarm_days,
                     interval: item_reg.repeat_secs};
        if (cmd.commit_set && item_reg.alarm_days != '0)
            wr_en = match_hit_reg || free_hit_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            table_mem[wr_addr] <= wr_entry;
        rd_entry_reg  <= table_mem[idx_reg];
        ent_valid_reg <= valid_reg[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            min_reg       <= wane_pkg::MIN_SCHED_RESET;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            day_busy_reg  <= 1'b0;
        end else begin
            if (cfg_valid)
                min_reg <= cfg_data;
            if (cmd.load_item)
                idx_reg <= '0;
            else if (cmd.next_idx)
                idx_reg <= idx_reg + IDX_W'(1);
            if (cmd.commit_set) begin
                if (item_reg.alarm_days == '0) begin
                    if (match_hit_reg)
                        valid_reg[match_idx_reg] <= 1'b0;
                end else if (!match_hit_reg && free_hit_reg) begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
            end
            if (cmd.div_day)
                day_busy_reg <= 1'b1;
            else if (cmd.pick)
                day_busy_reg <= 1'b0;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg      <= in_data;
            match_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
            best_reg      <= wane_pkg::NONE_MATCHED_MS;
            hit_reg       <= 1'b0;
        end
        if (cmd.scan_set) begin
            if (!match_hit_reg && ent_valid_reg &&
                rd_entry_reg.second == item_reg.alarm_second) begin
                match_hit_reg <= 1'b1;
                match_idx_reg <= idx_reg;
            end
            if (!free_hit_reg && !ent_valid_reg) begin
                free_hit_reg <= 1'b1;
                free_idx_reg <= idx_reg;
            end
        end
        if (cmd.div_start) begin
            ims_reg <= ims;
            neg_reg <= neg;
        end
        if (cmd.adjust)
            togo_reg <= togo_next;
        if (cmd.div_day) begin
            day_rem_reg <= {5'd0, item_reg.now_ms} + togo_reg;
            day_cnt_reg <= '0;
        end else if (day_busy_reg && day_left) begin
            day_rem_reg <= day_rem_reg - {1'b0, wane_pkg::MS_PER_DAY};
            day_cnt_reg <= day_cnt_reg + 5'd1;
        end
        if (cmd.pick && rd_entry_reg.days[target]) begin
            best_reg <= togo_reg[30:0];
            hit_reg  <= 1'b1;
        end
        if (cmd.commit_set) begin
            if (item_reg.alarm_days == '0)
                set_status_reg <= wane_pkg::STATUS_REMOVED;
            else if (match_hit_reg)
                set_status_reg <= wane_pkg::STATUS_UPDATED;
            else if (free_hit_reg)
                set_status_reg <= wane_pkg::STATUS_INSERTED;
            else
                set_status_reg <= wane_pkg::STATUS_FULL;
        end
        if (cmd.load_out) begin
            if (item_reg.operation == wane_pkg::OP_QUERY)
                out_reg <= '{status: wane_pkg::STATUS_QUERY, to_go_ms: best_reg,
                             found: hit_reg};
            else
                out_reg <= '{status: set_status_reg, to_go_ms: '0, found: 1'b0};
        end
    end

    assign sts.op_query     = item_reg.operation == wane_pkg::OP_QUERY;
    assign sts.last_idx     = idx_reg == IDX_W'(ALARM_ENTRIES - 1);
    assign sts.entry_ok     = ent_valid_reg && rd_entry_reg.interval != '0;
    assign sts.div_done     = div_done;
    assign sts.day_done     = day_busy_reg && !day_left;
    assign sts.togo_lt_best = togo_reg < {1'b0, best_reg};
    assign sts.out_busy     = out_valid_reg && !m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule
`default_nettype wire

// ===== sv/wane_ctrl.sv =====
`default_nettype none
module wane_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire wane_pkg::wane_sts_t sts,
    output wane_pkg::wane_cmd_t      cmd
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RD     = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_DIV1   = 3'd3;
    localparam logic [2:0] ST_CMP    = 3'd4;
    localparam logic [2:0] ST_DIV2   = 3'd5;
    localparam logic [2:0] ST_COMMIT = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = state_reg == ST_IDLE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_RD;
                end
            end
            ST_RD: state_next = ST_EVAL;
            ST_EVAL: begin
                if (!sts.op_query) begin
                    cmd.scan_set = 1'b1;
                    if (sts.last_idx) begin
                        state_next = ST_COMMIT;
                    end else begin
                        cmd.next_idx = 1'b1;
                        state_next   = ST_RD;
                    end
                end else if (sts.entry_ok) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV1;
                end else if (sts.last_idx) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.next_idx = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_DIV1: begin
                if (sts.div_done) begin
                    cmd.adjust = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (sts.togo_lt_best) begin
                    cmd.div_day = 1'b1;
                    state_next  = ST_DIV2;
                end else if (sts.last_idx) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.next_idx = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_DIV2: begin
                if (sts.day_done) begin
                    cmd.pick = 1'b1;
                    if (sts.last_idx) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.next_idx = 1'b1;
                        state_next   = ST_RD;
                    end
                end
            end
            ST_COMMIT: begin
                cmd.commit_set = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register frees up
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/weekly_alarm_next_event_unit.sv =====
// channel | direction | handshake           | word
// s_      | in        | s_valid / s_ready   | wane_in_t: set or query item
// m_      | out       | m_valid / m_ready   | wane_out_t: status, to_go_ms, found
// cfg_    | in        | cfg_valid/cfg_ready | min_schedule_ms, 27 bits
// One item at a time; s_ready is high in idle only.
// A set reads and scans each table entry, then commits and loads the word.
// A query reads each entry, runs the modulo through the shared 32-step divider
// on each live entry with a nonzero interval, counts days on each entry that
// beats the best time, then loads the word.
// Reset clears the valid bits at once. A stalled word holds the load of the next.
`default_nettype none
`include "weekly_alarm_next_event_unit_macros.svh"
module weekly_alarm_next_event_unit #(
    parameter int ALARM_ENTRIES = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire wane_pkg::wane_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output wane_pkg::wane_out_t     m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [26:0]        cfg_data
);
    wane_pkg::wane_cmd_t cmd;
    wane_pkg::wane_sts_t sts;
    logic                answer_word;
    logic                set_word;
    logic                none_time;

    assign cfg_ready = 1'b1;

    wane_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wane_datapath #(
        .ALARM_ENTRIES (ALARM_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    assign answer_word = m_valid && m_data.status == wane_pkg::STATUS_QUERY;
    assign set_word    = m_valid && m_data.status != wane_pkg::STATUS_QUERY;
    assign none_time   = m_data.to_go_ms == wane_pkg::NONE_MATCHED_MS;

    `WANE_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "item accepted while busy")
    `WANE_ASSERT(a_none_matched, answer_word && !m_data.found |-> none_time, "no match not 24 days")
    `WANE_ASSERT(a_set_clean, set_word |-> m_data.to_go_ms == '0 && !m_data.found, "set word dirty")
endmodule
`default_nettype wire
